>>> hw/rtl/mwr_pkg.sv
package mwr_pkg;

    // Control register bits
    localparam logic [7:0] CTL_ENB  = 8'h80;
    localparam logic [7:0] CTL_CS   = 8'h08;
    localparam logic [7:0] CTL_SK   = 8'h04;
    localparam logic [7:0] CTL_DI   = 8'h02;
    localparam logic [7:0] CTL_DONE = 8'hF7;

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam int          CMD_W     = 13;
    localparam logic [2:0]  READ_OP   = 3'b110;
    localparam logic [3:0]  MAX_WIDTH = 4'd8;
    localparam logic [3:0]  CMD_EXTRA = 4'd5;   // start bit + opcode + 2 bit slack

    typedef struct packed {
        logic       action;
        logic [7:0] word_address;
        logic [3:0] address_width;
        logic       serial_data_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  control_byte;
        logic        word_ready;
        logic [15:0] read_word;
    } result_t;

endpackage

>>> hw/rtl/mwr_ifs.sv
interface mwr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] word_address;
    logic [3:0] address_width;
    logic       serial_data_in;

    modport source (output valid, action, word_address, address_width, serial_data_in,
                    input ready);
    modport sink   (input valid, action, word_address, address_width, serial_data_in,
                    output ready);
endinterface

interface mwr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  control_byte;
    logic        word_ready;
    logic [15:0] read_word;

    modport source (output valid, control_byte, word_ready, read_word, input ready);
    modport sink   (input valid, control_byte, word_ready, read_word, output ready);
endinterface

>>> hw/rtl/microwire_eeprom_read_sequencer.sv
// Three-wire serial EEPROM read sequencer.
// in_ch carries items: action 0 arms a read (address and width latched,
// widths above 8 held at 8; ignored while a read runs), action 1 is one tick
// that yields the next control-register byte. out_ch carries one result per
// tick while a read runs: control_byte, and on the last tick word_ready with
// the assembled read_word (zero otherwise).
// A read takes 2 + 2*(width+5) + 1 + 2*WORD_BITS + 1 ticks, 62 at width 8.
// A tick's result is captured in the output register in the cycle after its
// transfer. Throughput: one item per cycle while the receiver keeps up; the
// step counter and shift register update on each accepted item, and the output
// register lets the next item in while the previous result is still on offer.
// If the receiver stalls with a result held, in_ch.ready drops until that
// result is taken; starts and idle ticks are blocked the same way.
// Reset clears the sequencer to idle and empties the output register.
module microwire_eeprom_read_sequencer
    import mwr_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input logic      clk,
    input logic      rst_n,
    mwr_in_if.sink   in_ch,
    mwr_out_if.source out_ch
);

    in_item_t item;
    result_t  res;
    result_t  out_res;
    logic     res_valid;
    logic     can_take;
    logic     take;

    assign item.action         = in_ch.action;
    assign item.word_address   = in_ch.word_address;
    assign item.address_width  = in_ch.address_width;
    assign item.serial_data_in = in_ch.serial_data_in;

    assign in_ch.ready = can_take;
    assign take        = in_ch.valid && can_take;

    // step counter, command register and data shift register
    mwr_seq_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register towards out_ch
    mwr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res)
    );

    assign out_ch.control_byte = out_res.control_byte;
    assign out_ch.word_ready   = out_res.word_ready;
    assign out_ch.read_word    = out_res.read_word;

    // The final transfer of a read always writes the release value
    a_done_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.word_ready |-> out_ch.control_byte == CTL_DONE)
        else $error("word_ready without release byte");

    // Word is only presented on the final tick
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.word_ready |-> out_ch.read_word == 16'h0000)
        else $error("read_word non-zero before the end of a read");

    // A held result blocks the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("input accepted while result stalled");

    // Enable bit is set in every byte written
    a_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.control_byte[7])
        else $error("enable bit clear");

endmodule

>>> hw/rtl/mwr_seq_core.sv
module mwr_seq_core
    import mwr_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    localparam int STEP_W = $clog2(2 * WORD_BITS + 30);
    localparam logic [STEP_W-1:0] DATA_STEPS = STEP_W'(2 * WORD_BITS);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [3:0]        width_reg, width_next;
    logic [15:0]       shift_reg, shift_next;

    logic [3:0]        w_sat;
    logic [4:0]        nbits;
    logic [STEP_W-1:0] cmd_end;
    logic [STEP_W-1:0] data_end;
    logic [STEP_W-1:0] k;
    logic [STEP_W-1:0] sel;
    logic [3:0]        idx;
    logic [7:0]        ctl;
    logic              done;

    always_comb
    begin
        w_sat    = (item.address_width > MAX_WIDTH) ? MAX_WIDTH : item.address_width;
        nbits    = {1'b0, width_reg} + {1'b0, CMD_EXTRA};
        cmd_end  = STEP_W'(2) + STEP_W'({nbits, 1'b0});
        data_end = cmd_end + STEP_W'(1) + DATA_STEPS;
        k        = step_reg - STEP_W'(2);
        sel      = step_reg - (cmd_end + STEP_W'(1));
        idx      = 4'(nbits - 5'd1 - 5'(k >> 1));
        done     = 1'b0;
        shift_next = shift_reg;

        if (step_reg == '0) begin
            ctl = CTL_ENB;
        end else if (step_reg == STEP_W'(1)) begin
            ctl = CTL_ENB | CTL_CS;
        end else if (step_reg < cmd_end) begin
            // command bit, clock low then clock high
            ctl = CTL_ENB | CTL_CS | (cmd_reg[idx] ? CTL_DI : 8'h00) | (k[0] ? CTL_SK : 8'h00);
        end else if (step_reg == cmd_end) begin
            ctl = CTL_ENB | CTL_CS;
        end else if (step_reg < data_end) begin
            if (!sel[0]) begin
                ctl        = CTL_ENB | CTL_CS | CTL_SK;
                shift_next = {shift_reg[14:0], item.serial_data_in};
            end else begin
                ctl = CTL_ENB | CTL_CS;
            end
        end else begin
            ctl  = CTL_DONE;
            done = 1'b1;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        width_next = width_reg;
        res_valid  = 1'b0;
        res.control_byte = ctl;
        res.word_ready   = done;
        res.read_word    = done ? shift_reg : 16'h0000;

        if (take) begin
            if (item.action == ACT_START) begin
                if (!busy_reg) begin
                    width_next = w_sat;
                    cmd_next   = CMD_W'(item.word_address) | (CMD_W'(READ_OP) << w_sat);
                    step_next  = '0;
                    busy_next  = 1'b1;
                end
            end else if (busy_reg) begin
                res_valid = 1'b1;
                busy_next = !done;
                step_next = done ? '0 : step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            cmd_reg   <= '0;
            width_reg <= '0;
            shift_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            cmd_reg   <= cmd_next;
            width_reg <= width_next;
            if (take && item.action == ACT_START && !busy_reg)
                shift_reg <= '0;
            else if (take && item.action == ACT_TICK && busy_reg)
                shift_reg <= shift_next;
        end
    end

endmodule

>>> hw/rtl/mwr_out_reg.sv
module mwr_out_reg
    import mwr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    input  result_t res,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // room when empty or draining this cycle
    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_take)
            valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res_valid)
            data_reg <= res;
    end

endmodule
